// ===== rtl/ldas_pkg.sv =====
// Package for the log-domain add/subtract block: default sizes, output flag
// positions and the elaboration-time functions that build the correction tables.
// No dependencies.
`default_nettype none

package ldas_pkg;

  localparam int VALUE_WIDTH_DEF      = 24;
  localparam int FRAC_BITS_DEF        = 12;
  localparam int TABLE_INDEX_BITS_DEF = 8;

  // out_tuser bit positions
  localparam int FLAG_INVALID   = 0;
  localparam int FLAG_SATURATED = 1;
  localparam int FLAG_W         = 2;

  localparam logic [63:0]        WORK_ONE = 64'h0000_0001_0000_0000;
  localparam logic signed [63:0] LN2_Q32  = 64'sd2977044472;

  typedef logic [63:0]        u64_t;
  typedef logic signed [63:0] s64_t;

  // Q32 product, rounded half up.
  function automatic u64_t qmul(input u64_t a, input u64_t b);
    u64_t p;
    p = a * b;
    return (p + 64'h0000_0000_8000_0000) >> 32;
  endfunction

  // Restoring long division, used only while building the tables.
  function automatic u64_t udiv(input u64_t num, input u64_t den);
    logic [64:0] rem;
    u64_t        quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-u, Q32, 17-term series.
  function automatic u64_t exp_neg_q32(input u64_t u);
    s64_t sum;
    u64_t term;
    sum  = $signed(WORK_ONE);
    term = WORK_ONE;
    for (int n = 1; n <= 16; n++) begin
      term = udiv(qmul(term, u), 64'(n));
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    return (sum > 0) ? $unsigned(sum) : '0;
  endfunction

  // Natural log, Q32 in and out: normalize to [1,2), then atanh series.
  function automatic s64_t ln_q32(input u64_t v);
    u64_t vv;
    u64_t t;
    u64_t t2;
    u64_t pw;
    u64_t acc;
    s64_t shifts;
    vv     = (v == '0) ? 64'd1 : v;
    shifts = '0;
    acc    = '0;
    while (vv < WORK_ONE) begin
      vv     = vv << 1;
      shifts = shifts + 1;
    end
    while (vv >= (WORK_ONE << 1)) begin
      vv     = vv >> 1;
      shifts = shifts - 1;
    end
    t  = udiv((vv - WORK_ONE) << 32, vv + WORK_ONE);
    t2 = qmul(t, t);
    pw = t;
    for (int n = 1; n <= 39; n += 2) begin
      acc = acc + udiv(pw, 64'(n));
      pw  = qmul(pw, t2);
    end
    return $signed(acc << 1) - shifts * LN2_Q32;
  endfunction

  // Round Q32 to frac_bits, ties away from zero.
  function automatic s64_t q32_to_frac(input s64_t v, input int frac_bits);
    int   s;
    u64_t half;
    u64_t mag;
    s    = 32 - frac_bits;
    half = 64'd1 << (s - 1);
    if (v < 0) begin
      mag = ($unsigned(-v) + half) >> s;
      return -$signed(mag);
    end
    mag = ($unsigned(v) + half) >> s;
    return $signed(mag);
  endfunction

  // One correction entry: ln(1+y_k) for a sum, ln(1-y_k) for a difference,
  // y_k = e^-x_k at the midpoint of bin k.
  function automatic s64_t corr_entry(input int k, input logic is_sub,
                                      input int frac_bits, input int index_bits);
    u64_t e1;
    u64_t e2;
    u64_t y;
    e1 = exp_neg_q32(64'd1 << (35 - index_bits));
    e2 = qmul(e1, e1);
    y  = e1;
    for (int j = 0; j < k; j++) begin
      y = qmul(y, e2);
    end
    if (is_sub) begin
      return q32_to_frac(ln_q32((y < WORK_ONE) ? (WORK_ONE - y) : 64'd1), frac_bits);
    end
    return q32_to_frac(ln_q32(WORK_ONE + y), frac_bits);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/log_domain_add_subtract_top.sv =====
// Log-domain add/subtract (Jacobian logarithm), one result per item.
// Depends on ldas_pkg (defaults, flag positions, correction table builder).
`default_nettype none

// Usage
//   Input channel in_*: in_tdata carries first_log (low VALUE_WIDTH bits) and
//   second_log (next VALUE_WIDTH bits); in_tuser carries req_type (0 = sum,
//   1 = difference). An item is taken when in_tvalid and in_tready are high.
//   Result channel out_*: out_tdata carries result_log, out_tuser carries
//   invalid (bit 0) and saturated (bit 1).
//   Sum:        max(a,b) + ln(1 + e^-d), d = |a - b|.
//   Difference: a + ln(1 - e^-d); with b >= a the result is the most negative
//   value and invalid is set. Overflow clamps to the range and sets saturated.
//   The correction is read from a constant table of 2^TABLE_INDEX_BITS entries
//   over d in [0,16); d of 16 or more adds nothing.
// Timing
//   An accepted item is held in the input register, then one pass of compare,
//   table read and add loads the result register, which drives out_tvalid.
//   Throughput is one item per cycle while the receiver does not stall.
//   Reset clears both valid flags; the payload registers are not reset.
//   When the receiver stalls, the result register holds and the input stage
//   still takes one more item if empty; after that in_tready drops until out_tready.
module log_domain_add_subtract_top #(
  parameter int VALUE_WIDTH      = ldas_pkg::VALUE_WIDTH_DEF,
  parameter int FRAC_BITS        = ldas_pkg::FRAC_BITS_DEF,
  parameter int TABLE_INDEX_BITS = ldas_pkg::TABLE_INDEX_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // [VALUE_WIDTH-1:0] first_log, [2*VALUE_WIDTH-1:VALUE_WIDTH] second_log, zero pad
  input  wire logic [((2*VALUE_WIDTH+7)/8)*8-1:0]    in_tdata,
  // [0] req_type
  input  wire logic                                  in_tuser,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // [VALUE_WIDTH-1:0] result_log, zero pad
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]           out_tdata,
  // [0] invalid, [1] saturated
  output logic [ldas_pkg::FLAG_W-1:0]                out_tuser
);

  localparam int VW       = VALUE_WIDTH;
  localparam int TBL_SIZE = 1 << TABLE_INDEX_BITS;
  localparam int SHIFT    = FRAC_BITS + 4 - TABLE_INDEX_BITS;
  localparam int CW       = FRAC_BITS + 5;   // corrections lie within (-16, 16)
  localparam int DW       = (VW > FRAC_BITS + 5) ? VW : FRAC_BITS + 5;
  localparam int SW       = ((VW > CW) ? VW : CW) + 1;
  localparam int OUT_DW   = ((VALUE_WIDTH + 7) / 8) * 8;

  localparam logic signed [SW-1:0] VMAX_EXT = SW'((64'd1 << (VW - 1)) - 64'd1);
  localparam logic signed [SW-1:0] VMIN_EXT = -VMAX_EXT - SW'(1);
  localparam logic signed [VW-1:0] VMIN     = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] VMAX     = {1'b0, {(VW-1){1'b1}}};

  // Correction tables, folded to constants at elaboration.
  logic signed [CW-1:0] add_tab [TBL_SIZE];
  logic signed [CW-1:0] sub_tab [TBL_SIZE];

  for (genvar k = 0; k < TBL_SIZE; k++) begin : g_tab
    localparam logic signed [CW-1:0] ADD_K =
      CW'(ldas_pkg::corr_entry(k, 1'b0, FRAC_BITS, TABLE_INDEX_BITS));
    localparam logic signed [CW-1:0] SUB_K =
      CW'(ldas_pkg::corr_entry(k, 1'b1, FRAC_BITS, TABLE_INDEX_BITS));
    assign add_tab[k] = ADD_K;
    assign sub_tab[k] = SUB_K;
  end

  // Handshake: the result register frees when empty or taken; the input
  // register frees when empty or moving forward.
  logic s1_valid_r;
  logic s1_type_r;
  logic signed [VW-1:0] s1_a_r;
  logic signed [VW-1:0] s1_b_r;
  logic out_valid_r;
  logic signed [VW-1:0] out_result_r;
  logic out_invalid_r;
  logic out_sat_r;
  logic s2_ready;
  logic s1_ready;

  assign s2_ready  = !out_valid_r || out_tready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Capture the item as it is accepted.
  always_ff @(posedge clk) begin
    if (in_tvalid && s1_ready) begin
      s1_type_r <= in_tuser;
      s1_a_r    <= $signed(in_tdata[VW-1:0]);
      s1_b_r    <= $signed(in_tdata[2*VW-1:VW]);
    end
  end

  // Datapath: distance, table read, add, clamp.
  logic signed [VW:0]    diff;
  logic signed [VW:0]    diff_neg;
  logic                  a_gt_b;
  logic [VW-1:0]         abs_diff;
  logic [DW-1:0]         abs_diff_ext;
  logic [TABLE_INDEX_BITS-1:0] idx;
  logic                  in_range;
  logic signed [CW-1:0]  corr;
  logic signed [VW-1:0]  base;
  logic signed [SW-1:0]  total;
  logic signed [VW-1:0]  result_nxt;
  logic                  invalid_nxt;
  logic                  sat_nxt;

  always_comb begin
    diff         = {s1_a_r[VW-1], s1_a_r} - {s1_b_r[VW-1], s1_b_r};
    diff_neg     = -diff;
    a_gt_b       = !diff[VW] && (diff != '0);
    // |a - b| always fits VW unsigned bits
    abs_diff     = diff[VW] ? diff_neg[VW-1:0] : diff[VW-1:0];
    abs_diff_ext = DW'(abs_diff);
    idx          = abs_diff_ext[SHIFT +: TABLE_INDEX_BITS];
    in_range     = (abs_diff_ext >> (FRAC_BITS + 4)) == '0;

    if (!in_range) begin
      corr = '0;
    end else if (s1_type_r) begin
      corr = sub_tab[idx];
    end else begin
      corr = add_tab[idx];
    end

    base  = (s1_type_r || a_gt_b) ? s1_a_r : s1_b_r;
    total = SW'(base) + SW'(corr);

    invalid_nxt = s1_type_r && !a_gt_b;
    sat_nxt     = 1'b0;
    result_nxt  = total[VW-1:0];
    if (invalid_nxt) begin
      result_nxt = VMIN;
    end else if (total > VMAX_EXT) begin
      result_nxt = VMAX;
      sat_nxt    = 1'b1;
    end else if (total < VMIN_EXT) begin
      result_nxt = VMIN;
      sat_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Load the result register when it frees; hold it while stalled.
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      out_result_r  <= result_nxt;
      out_invalid_r <= invalid_nxt;
      out_sat_r     <= sat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'($unsigned(out_result_r));
  always_comb begin
    out_tuser                           = '0;
    out_tuser[ldas_pkg::FLAG_INVALID]   = out_invalid_r;
    out_tuser[ldas_pkg::FLAG_SATURATED] = out_sat_r;
  end

endmodule

`default_nettype wire

// ===== rtl/ldas_checker.sv =====
// Port-level checker for the log-domain add/subtract block, bound to the top.
// Depends on ldas_pkg for defaults and flag positions.
`default_nettype none

module ldas_checker #(
  parameter int VALUE_WIDTH = ldas_pkg::VALUE_WIDTH_DEF
) (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [((VALUE_WIDTH+7)/8)*8-1:0]   out_tdata,
  input wire logic [ldas_pkg::FLAG_W-1:0]        out_tuser
);

  localparam logic [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  logic flag_inv;
  logic flag_sat;
  assign flag_inv = out_tuser[ldas_pkg::FLAG_INVALID];
  assign flag_sat = out_tuser[ldas_pkg::FLAG_SATURATED];

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Reset leaves the output empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // An invalid difference gives the minimum value and no saturation.
  a_invalid_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && flag_inv |-> out_tdata[VALUE_WIDTH-1:0] == VMIN && !flag_sat)
    else $error("invalid result not at minimum");

  // A clamped result sits at one end of the range.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && flag_sat |->
      out_tdata[VALUE_WIDTH-1:0] == VMAX || out_tdata[VALUE_WIDTH-1:0] == VMIN)
    else $error("saturated result not at a range limit");

  // A result that appears at an empty output comes from an accepted item that passed through the input register.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid ##1 out_tvalid |-> $past(in_tvalid && in_tready, 2))
    else $error("result without item");

endmodule

bind log_domain_add_subtract_top ldas_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_ldas_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

`default_nettype wire
